@@ src/fpst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpst_pkg
// Shared sizes, types and helpers for the Fenwick prefix-sum table.
// ----------------------------------------------------------------------------
package fpst_pkg;

    localparam int SIZE    = 1024;
    localparam int IDX_W   = 11;
    localparam int DELTA_W = 32;
    localparam int SUM_W   = 64;
    localparam int ADDR_W  = $clog2(SIZE);
    // room for a position just above the tree while climbing
    localparam int POS_W   = $clog2(SIZE + 1) + 1;
    localparam int CMP_W   = (POS_W > IDX_W) ? POS_W : IDX_W;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic load;
        logic mode;
        logic accumulate;
        logic wr_en;
        logic wr_zero;
        logic out_load;
    } dp_ctrl_t;

    function automatic pos_t low_bit(pos_t x);
        return x & (~x + pos_t'(1));
    endfunction

endpackage

@@ src/fpst_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpst_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fpst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/fpst_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpst_ctrl
// Sequencer: clearing pass, request acceptance and the tree walk.
// ----------------------------------------------------------------------------
module fpst_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_mode,
    input  logic [fpst_pkg::IDX_W-1:0] s_index,
    input  logic                      out_busy,
    output fpst_pkg::dp_ctrl_t        dp_ctrl,
    output logic                      ram_re,
    output fpst_pkg::addr_t           ram_raddr,
    output fpst_pkg::addr_t           ram_waddr
);

    fpst_pkg::state_t state_reg, state_next;
    fpst_pkg::pos_t   pos_reg, pos_next;
    fpst_pkg::pos_t   start_pos;
    fpst_pkg::pos_t   step;
    fpst_pkg::addr_t  waddr_reg, waddr_next;
    fpst_pkg::addr_t  clr_cnt_reg, clr_cnt_next;
    fpst_pkg::addr_t  pos_addr;
    fpst_pkg::pos_t   pos_dec;
    logic             pending_reg, pending_next;
    logic             mode_reg, mode_next;
    logic             pos_live;
    logic             idx_over;
    logic             take;

    assign pos_live = (pos_reg != '0) && (pos_reg <= fpst_pkg::pos_t'(fpst_pkg::SIZE));
    assign pos_dec  = pos_reg - fpst_pkg::pos_t'(1);
    assign pos_addr = pos_dec[fpst_pkg::ADDR_W-1:0];
    assign step     = fpst_pkg::low_bit(pos_reg);
    assign idx_over = fpst_pkg::CMP_W'(s_index) > fpst_pkg::CMP_W'(fpst_pkg::SIZE);
    assign take     = (state_reg == fpst_pkg::ST_IDLE) && s_valid;

    // query beyond the tree clamps, update beyond it touches nothing
    always_comb begin
        if (!idx_over) begin
            start_pos = fpst_pkg::pos_t'(s_index);
        end else if (s_mode == fpst_pkg::MODE_QUERY) begin
            start_pos = fpst_pkg::pos_t'(fpst_pkg::SIZE);
        end else begin
            start_pos = '0;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fpst_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == fpst_pkg::addr_t'(fpst_pkg::SIZE - 1)) begin
                    state_next = fpst_pkg::ST_IDLE;
                end
            end
            fpst_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = fpst_pkg::ST_WALK;
                end
            end
            fpst_pkg::ST_WALK: begin
                if (!pos_live && !pending_reg && !out_busy) begin
                    state_next = fpst_pkg::ST_IDLE;
                end
            end
            default: state_next = fpst_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        s_ready            = 1'b0;
        ram_re             = 1'b0;
        dp_ctrl            = '0;
        dp_ctrl.mode       = mode_reg;
        ram_raddr          = pos_addr;
        ram_waddr          = waddr_reg;
        unique case (state_reg)
            fpst_pkg::ST_CLEAR: begin
                dp_ctrl.wr_en   = 1'b1;
                dp_ctrl.wr_zero = 1'b1;
                ram_waddr       = clr_cnt_reg;
            end
            fpst_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                dp_ctrl.load = s_valid;
            end
            fpst_pkg::ST_WALK: begin
                ram_re             = pos_live;
                dp_ctrl.accumulate = pending_reg && (mode_reg == fpst_pkg::MODE_QUERY);
                dp_ctrl.wr_en      = pending_reg && (mode_reg == fpst_pkg::MODE_ADD);
                dp_ctrl.out_load   = !pos_live && !pending_reg && !out_busy;
            end
            default: ;
        endcase
    end

    always_comb begin
        pos_next     = pos_reg;
        pending_next = 1'b0;
        waddr_next   = waddr_reg;
        mode_next    = mode_reg;
        clr_cnt_next = clr_cnt_reg;
        if (state_reg == fpst_pkg::ST_CLEAR) begin
            clr_cnt_next = clr_cnt_reg + fpst_pkg::addr_t'(1);
        end
        if (take) begin
            pos_next  = start_pos;
            mode_next = s_mode;
        end
        if ((state_reg == fpst_pkg::ST_WALK) && pos_live) begin
            pending_next = 1'b1;
            waddr_next   = pos_addr;
            pos_next     = (mode_reg == fpst_pkg::MODE_QUERY) ? pos_reg - step
                                                               : pos_reg + step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fpst_pkg::ST_CLEAR;
            pos_reg     <= '0;
            pending_reg <= 1'b0;
            waddr_reg   <= '0;
            mode_reg    <= fpst_pkg::MODE_ADD;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            pending_reg <= pending_next;
            waddr_reg   <= waddr_next;
            mode_reg    <= mode_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

endmodule

@@ src/fpst_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpst_dp
// Datapath: one shared 64-bit adder for cell updates and prefix accumulation.
// ----------------------------------------------------------------------------
module fpst_dp (
    input  logic                        aclk,
    input  fpst_pkg::dp_ctrl_t          dp_ctrl,
    input  logic [fpst_pkg::DELTA_W-1:0] s_delta,
    input  logic [fpst_pkg::SUM_W-1:0]   rdata,
    output logic [fpst_pkg::SUM_W-1:0]   wdata,
    output logic [fpst_pkg::SUM_W-1:0]   result
);

    logic [fpst_pkg::DELTA_W-1:0] delta_reg, delta_next;
    logic [fpst_pkg::SUM_W-1:0]   acc_reg, acc_next;
    logic [fpst_pkg::SUM_W-1:0]   delta_ext;
    logic [fpst_pkg::SUM_W-1:0]   sum;

    assign delta_ext = {{(fpst_pkg::SUM_W - fpst_pkg::DELTA_W){delta_reg[fpst_pkg::DELTA_W-1]}},
                        delta_reg};
    assign sum       = rdata + ((dp_ctrl.mode == fpst_pkg::MODE_QUERY) ? acc_reg : delta_ext);
    assign wdata     = dp_ctrl.wr_zero ? '0 : sum;
    assign result    = (dp_ctrl.mode == fpst_pkg::MODE_QUERY) ? acc_reg : '0;

    always_comb begin
        delta_next = delta_reg;
        acc_next   = acc_reg;
        if (dp_ctrl.load) begin
            delta_next = s_delta;
            acc_next   = '0;
        end else if (dp_ctrl.accumulate) begin
            acc_next = sum;
        end
    end

    always_ff @(posedge aclk) begin
        delta_reg <= delta_next;
        acc_reg   <= acc_next;
    end

endmodule

@@ src/fenwick_prefix_sum_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenwick_prefix_sum_table_top
// Binary indexed tree over 1024 positions: point updates and prefix sums.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel s_*: s_mode 0 adds s_delta at s_index, s_mode 1 asks for
//   the sum of positions 1..s_index (clamped to the tree size). Every request
//   gives one response on m_*; m_prefix_sum is zero for an update.
//   A request walks k tree cells, k at most 11, one RAM access per cycle with
//   a read-modify-write overlapped with the next read. The response is loaded
//   into the output register once the last cell has been handled.
//   s_ready is low from acceptance until the response is registered.
//   The output register holds a response while m_ready is low, and the next
//   request may be accepted meanwhile; its walk then waits at the end until
//   the register frees up.
//   Reset: after aresetn is released the RAM is zeroed by a clearing pass over
//   all 1024 cells, during which s_ready stays low.
// ----------------------------------------------------------------------------
module fenwick_prefix_sum_table_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_mode,
    input  logic        [fpst_pkg::IDX_W-1:0]   s_index,
    input  logic signed [fpst_pkg::DELTA_W-1:0] s_delta,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [fpst_pkg::SUM_W-1:0]   m_prefix_sum
);

    fpst_pkg::dp_ctrl_t         dp_ctrl;
    fpst_pkg::addr_t            ram_raddr;
    fpst_pkg::addr_t            ram_waddr;
    logic                       ram_re;
    logic [fpst_pkg::SUM_W-1:0] ram_rdata;
    logic [fpst_pkg::SUM_W-1:0] ram_wdata;
    logic [fpst_pkg::SUM_W-1:0] result;
    logic                       out_busy;
    logic                       m_valid_reg, m_valid_next;
    logic [fpst_pkg::SUM_W-1:0] m_sum_reg, m_sum_next;

    assign out_busy = m_valid_reg && !m_ready;

    fpst_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_mode    (s_mode),
        .s_index   (s_index),
        .out_busy  (out_busy),
        .dp_ctrl   (dp_ctrl),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_waddr (ram_waddr)
    );

    fpst_dp u_dp (
        .aclk    (aclk),
        .dp_ctrl (dp_ctrl),
        .s_delta (s_delta),
        .rdata   (ram_rdata),
        .wdata   (ram_wdata),
        .result  (result)
    );

    fpst_ram #(
        .WIDTH (fpst_pkg::SUM_W),
        .DEPTH (fpst_pkg::SIZE)
    ) u_ram (
        .aclk  (aclk),
        .we    (dp_ctrl.wr_en),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_sum_next   = m_sum_reg;
        if (dp_ctrl.out_load) begin
            m_valid_next = 1'b1;
            m_sum_next   = result;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_sum_reg <= m_sum_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_prefix_sum = m_sum_reg;

endmodule

@@ src/fpst_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpst_checker
// Port-level checks for the Fenwick prefix-sum table, bound to the top level.
// ----------------------------------------------------------------------------
module fpst_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [fpst_pkg::SUM_W-1:0]  m_prefix_sum
);

    // clearing pass keeps requests out and nothing is pending
    a_reset_quiet: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> (!s_ready && !m_valid))
        else $error("fpst: ready or response right after reset");

    // one request at a time
    a_single_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("fpst: ready straight after an accepted request");

    // a response only follows a walk, during which ready is low
    a_resp_after_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("fpst: response appeared without a walk");

    a_resp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_prefix_sum)))
        else $error("fpst: stalled response changed");

endmodule

bind fenwick_prefix_sum_table_top fpst_checker u_fpst_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_prefix_sum (m_prefix_sum)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks fenwick_prefix_sum_table_top by comparing every response with its own binary
// indexed tree or with a literal expectation sent along with the request. A short table
// of directed requests comes first, then random updates and queries, with random idling
// on both channels and one long back-pressure stretch on the response side.
// ----------------------------------------------------------------------------
module testbench;

    localparam int N_DIRECTED  = 25;
    localparam int N_RANDOM    = 1500;
    localparam int WATCH_LIMIT = 4000;
    localparam int HOLD_CYCLES = 250;
    localparam int HOLD_AT     = 300;
    localparam int QUIET_FROM  = 700;
    localparam int QUIET_TO    = 1000;
    localparam int DRAIN_WAIT  = 30;

    typedef struct packed {
        logic                                mode;
        logic [fpst_pkg::IDX_W-1:0]          index;
        logic signed [fpst_pkg::DELTA_W-1:0] delta;
        logic                                typed;
        logic signed [fpst_pkg::SUM_W-1:0]   sum;
    } stim_row_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic                                s_mode = fpst_pkg::MODE_ADD;
    logic [fpst_pkg::IDX_W-1:0]          s_index = '0;
    logic signed [fpst_pkg::DELTA_W-1:0] s_delta = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic signed [fpst_pkg::SUM_W-1:0]   m_prefix_sum;

    // literal expectation travelling with the request on the bus
    logic                                req_typed = 1'b0;
    logic signed [fpst_pkg::SUM_W-1:0]   req_sum = '0;

    logic signed [fpst_pkg::SUM_W-1:0]   tree_cells [1:fpst_pkg::SIZE];
    logic signed [fpst_pkg::SUM_W-1:0]   pending_sums [$];
    int                                  accepted_count = 0;
    int                                  failures = 0;
    int                                  idle_cycles = 0;
    bit                                  hold_done = 1'b0;
    int                                  hold_left = 0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{fpst_pkg::MODE_QUERY, 11'd1024, 32'sd0,          1'b1, 64'sd0},
        '{fpst_pkg::MODE_QUERY, 11'd0,    32'sd0,          1'b1, 64'sd0},
        '{fpst_pkg::MODE_ADD,   11'd0,    32'h7fffffff,    1'b1, 64'sd0},
        '{fpst_pkg::MODE_QUERY, 11'd1024, 32'sd0,          1'b1, 64'sd0},
        '{fpst_pkg::MODE_ADD,   11'd1,    32'h7fffffff,    1'b1, 64'sd0},
        '{fpst_pkg::MODE_ADD,   11'd1024, 32'h80000000,    1'b1, 64'sd0},
        '{fpst_pkg::MODE_QUERY, 11'd1,    32'sd0,          1'b1, 64'sd2147483647},
        '{fpst_pkg::MODE_QUERY, 11'd1024, 32'sd0,          1'b1, -64'sd1},
        '{fpst_pkg::MODE_QUERY, 11'd1023, 32'sd0,          1'b1, 64'sd2147483647},
        '{fpst_pkg::MODE_ADD,   11'd1025, 32'sd5,          1'b1, 64'sd0},
        '{fpst_pkg::MODE_ADD,   11'd2047, 32'hffffffff,    1'b1, 64'sd0},
        '{fpst_pkg::MODE_QUERY, 11'd2047, 32'sd0,          1'b1, -64'sd1},
        '{fpst_pkg::MODE_QUERY, 11'd1025, 32'sd0,          1'b1, -64'sd1},
        '{fpst_pkg::MODE_ADD,   11'd512,  32'sd1000,       1'b1, 64'sd0},
        '{fpst_pkg::MODE_QUERY, 11'd511,  32'sd0,          1'b0, 64'sd0},
        '{fpst_pkg::MODE_QUERY, 11'd512,  32'sd0,          1'b0, 64'sd0},
        '{fpst_pkg::MODE_ADD,   11'd683,  32'h55555555,    1'b1, 64'sd0},
        '{fpst_pkg::MODE_ADD,   11'd1023, 32'hfffffff9,    1'b1, 64'sd0},
        '{fpst_pkg::MODE_QUERY, 11'd682,  32'h0f0f0f0f,    1'b0, 64'sd0},
        '{fpst_pkg::MODE_QUERY, 11'd683,  32'sd0,          1'b0, 64'sd0},
        '{fpst_pkg::MODE_QUERY, 11'd1022, 32'sd0,          1'b0, 64'sd0},
        '{fpst_pkg::MODE_QUERY, 11'd1024, 32'sd0,          1'b0, 64'sd0},
        '{fpst_pkg::MODE_ADD,   11'd1365, 32'haaaaaaaa,    1'b1, 64'sd0},
        '{fpst_pkg::MODE_QUERY, 11'd0,    32'sd0,          1'b1, 64'sd0},
        '{fpst_pkg::MODE_QUERY, 11'd1024, 32'sd0,          1'b0, 64'sd0}
    };

    fenwick_prefix_sum_table_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_index      (s_index),
        .s_delta      (s_delta),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_prefix_sum (m_prefix_sum)
    );

    always #4 aclk = ~aclk;

    function automatic void tree_update(int unsigned pos,
                                        logic signed [fpst_pkg::SUM_W-1:0] amount);
        int unsigned p;
        p = pos;
        if (p == 0) begin
            return;
        end
        while (p <= fpst_pkg::SIZE) begin
            tree_cells[p] = tree_cells[p] + amount;
            p = p + (p & (~p + 1));
        end
    endfunction

    function automatic logic signed [fpst_pkg::SUM_W-1:0] tree_prefix_sum(int unsigned pos);
        int unsigned                       p;
        logic signed [fpst_pkg::SUM_W-1:0] acc;
        acc = '0;
        p = (pos > fpst_pkg::SIZE) ? fpst_pkg::SIZE : pos;
        while (p != 0) begin
            acc = acc + tree_cells[p];
            p = p - (p & (~p + 1));
        end
        return acc;
    endfunction

    function automatic bit in_quiet_stretch();
        return accepted_count >= QUIET_FROM && accepted_count < QUIET_TO;
    endfunction

    // accept requests, predict, and check responses
    always @(posedge aclk) begin
        logic signed [fpst_pkg::SUM_W-1:0] predicted;
        logic signed [fpst_pkg::SUM_W-1:0] amount;
        logic signed [fpst_pkg::SUM_W-1:0] wanted;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                accepted_count = accepted_count + 1;
                amount = fpst_pkg::SUM_W'(s_delta);
                if (s_mode == fpst_pkg::MODE_ADD) begin
                    tree_update(32'(s_index), amount);
                    predicted = '0;
                end else begin
                    predicted = tree_prefix_sum(32'(s_index));
                end
                pending_sums.push_back(req_typed ? req_sum : predicted);
            end
            if (m_valid && m_ready) begin
                if (pending_sums.size() == 0) begin
                    $error("unexpected response, prefix_sum %0d", m_prefix_sum);
                    failures = failures + 1;
                end else begin
                    wanted = pending_sums.pop_front();
                    if (m_prefix_sum !== wanted) begin
                        $error("prefix_sum: expected %0d, got %0d", wanted, m_prefix_sum);
                        failures = failures + 1;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCH_LIMIT) begin
            $display("fenwick_prefix_sum_table_top: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // response side: random stalls, one long hold-off
    initial begin
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else if (!hold_done && accepted_count >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (in_quiet_stretch()) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 16);
            end
        end
    end

    // request side
    initial begin
        stim_row_t row;
        int        pick;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < N_DIRECTED + N_RANDOM; i++) begin
            if (i < N_DIRECTED) begin
                row = directed_rows[i];
            end else begin
                row.mode = 1'($urandom_range(1));
                pick = $urandom_range(99);
                if (pick < 5) begin
                    row.index = '0;
                end else if (pick < 10) begin
                    row.index = fpst_pkg::IDX_W'(fpst_pkg::SIZE);
                end else if (pick < 20) begin
                    row.index = fpst_pkg::IDX_W'($urandom_range(2047, fpst_pkg::SIZE + 1));
                end else begin
                    row.index = fpst_pkg::IDX_W'($urandom_range(fpst_pkg::SIZE, 1));
                end
                case ($urandom_range(9))
                    0: row.delta = 32'h7fffffff;
                    1: row.delta = 32'h80000000;
                    2, 3, 4: row.delta = $signed($urandom_range(2000)) - 1000;
                    default: row.delta = $urandom;
                endcase
                row.typed = (row.mode == fpst_pkg::MODE_ADD);
                row.sum = '0;
            end
            while (!in_quiet_stretch() && $urandom_range(99) < 16) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
            s_valid   <= 1'b1;
            s_mode    <= row.mode;
            s_index   <= row.index;
            s_delta   <= row.delta;
            req_typed <= row.typed;
            req_sum   <= row.sum;
            do @(posedge aclk); while (!(s_valid && s_ready));
            @(negedge aclk);
        end
        s_valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (failures == 0) begin
            $display("fenwick_prefix_sum_table_top: match");
        end else begin
            $display("fenwick_prefix_sum_table_top: mismatch");
        end
        $finish;
    end

    initial begin
        for (int k = 1; k <= fpst_pkg::SIZE; k++) begin
            tree_cells[k] = '0;
        end
    end

endmodule

@@ files.f @@
src/fpst_pkg.sv
src/fpst_ram.sv
src/fpst_ctrl.sv
src/fpst_dp.sv
src/fenwick_prefix_sum_table_top.sv
src/fpst_checker.sv
sim/testbench.sv
